[sv/modular_exponentiation_defines.svh]
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MX_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/modexp_pkg.sv]
// Types, constants and the microcode table of the modular exponentiation block.
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

	localparam int OPERAND_WIDTH = 31;
	localparam int CNT_W = $clog2(OPERAND_WIDTH);

	typedef logic [OPERAND_WIDTH-1:0] operand_t;

	localparam operand_t MODULUS_RESET = OPERAND_WIDTH'(1000000007);

	typedef enum logic [1:0] {
		OP_NOP,
		OP_WAIT_IN,
		OP_MUL,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_M_ZERO,
		COND_EXP_ZERO,
		COND_EXP_BIT_CLR
	} cond_t;

	typedef enum logic [1:0] {
		X_ONE,
		X_RES,
		X_BASE
	} xsel_t;

	typedef enum logic [1:0] {
		DEST_NONE,
		DEST_RES,
		DEST_BASE
	} dest_t;

	typedef enum logic [3:0] {
		STEP_IDLE     = 4'd0,
		STEP_CHECK_M  = 4'd1,
		STEP_REDUCE   = 4'd2,
		STEP_LOOP     = 4'd3,
		STEP_TEST_BIT = 4'd4,
		STEP_MUL_RES  = 4'd5,
		STEP_SQUARE   = 4'd6,
		STEP_ZERO     = 4'd7,
		STEP_EMIT     = 4'd8
	} step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		xsel_t x_sel;
		dest_t dest;
		logic  shift_exp;
		logic  clr_res;
	} ucode_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

	// Control store: a taken jump goes to target, otherwise to the next step.
	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE, x_sel: X_ONE,
			dest: DEST_NONE, shift_exp: 1'b0, clr_res: 1'b0};
		case (s)
			STEP_IDLE: begin
				w.op   = OP_WAIT_IN;
				w.cond = COND_NEVER;
			end
			STEP_CHECK_M: begin
				w.cond   = COND_M_ZERO;
				w.target = STEP_ZERO;
			end
			STEP_REDUCE: begin
				// base * 1 mod m reduces the base
				w.op    = OP_MUL;
				w.cond  = COND_NEVER;
				w.x_sel = X_ONE;
				w.dest  = DEST_BASE;
			end
			STEP_LOOP: begin
				w.cond   = COND_EXP_ZERO;
				w.target = STEP_EMIT;
			end
			STEP_TEST_BIT: begin
				w.cond   = COND_EXP_BIT_CLR;
				w.target = STEP_SQUARE;
			end
			STEP_MUL_RES: begin
				w.op    = OP_MUL;
				w.cond  = COND_NEVER;
				w.x_sel = X_RES;
				w.dest  = DEST_RES;
			end
			STEP_SQUARE: begin
				w.op        = OP_MUL;
				w.cond      = COND_ALWAYS;
				w.target    = STEP_LOOP;
				w.x_sel     = X_BASE;
				w.dest      = DEST_BASE;
				w.shift_exp = 1'b1;
			end
			STEP_ZERO: begin
				w.cond    = COND_ALWAYS;
				w.target  = STEP_EMIT;
				w.clr_res = 1'b1;
			end
			STEP_EMIT: begin
				w.op     = OP_EMIT;
				w.cond   = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[sv/modexp_mulmod.sv]
// Bit-serial modular multiplier: interleaved double-and-add with reduction.
`timescale 1ns / 1ps
`default_nettype none

module modexp_mulmod (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire modexp_pkg::operand_t x,
	input  wire modexp_pkg::operand_t y,
	input  wire modexp_pkg::operand_t m,
	output modexp_pkg::operand_t     result,
	output modexp_pkg::mm_stat_t     stat
);
	import modexp_pkg::*;

	// (a + b) mod m for a < m and b <= m
	function automatic operand_t add_mod(operand_t a, operand_t b, operand_t mod_v);
		logic [OPERAND_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, mod_v}) begin
			s = s - {1'b0, mod_v};
		end
		return s[OPERAND_WIDTH-1:0];
	endfunction

	operand_t         acc_q;
	operand_t         x_q;
	operand_t         y_q;
	logic [CNT_W-1:0] cnt_q;
	logic             phase_q;
	logic             active_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			phase_q  <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				phase_q  <= 1'b0;
				cnt_q    <= CNT_W'(OPERAND_WIDTH - 1);
			end else if (active_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (cnt_q == '0) begin
						active_q <= 1'b0;
						done_q   <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	// Scan y from its top bit: double on phase 0, add x on phase 1.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (active_q) begin
			if (!phase_q) begin
				acc_q <= add_mod(acc_q, acc_q, m);
			end else begin
				if (y_q[OPERAND_WIDTH-1]) begin
					acc_q <= add_mod(acc_q, x_q, m);
				end
				y_q <= {y_q[OPERAND_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign result    = acc_q;
	assign stat.busy = active_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

[sv/modular_exponentiation.sv]
// Modular exponentiation top level: microcoded sequencer around a serial mod-multiplier.
//
// Computes power_result = base_value ^ exponent mod modulus (right-to-left
// square and multiply). An exponent of zero gives 1; a modulus of zero gives 0.
// Input channel in_valid/in_ready carries base_value and exponent; output
// channel out_valid/out_ready carries power_result. A transaction completes
// when valid and ready are both high at a rising edge.
// The modulus is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// One item is worked on at a time. Each modular multiply runs on the shared
// bit-serial unit, with a doubling phase and an adding phase per operand bit.
// The next item can be accepted in the cycle after the result register is written.
// The result register parts the output from the sequencer: a new item is
// accepted while an earlier result still waits; a stalled receiver holds the
// sequencer only when a second result is ready to be written.
// Reset clears the sequencer and output valid, and sets the modulus to 1000000007.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire modexp_pkg::operand_t cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire modexp_pkg::operand_t base_value,
	input  wire modexp_pkg::operand_t exponent,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output modexp_pkg::operand_t      power_result
);
	import modexp_pkg::*;

	step_t    pc_q;
	step_t    pc_d;
	ucode_t   word;
	logic     step_done;
	logic     cond_true;
	logic     mul_start;
	logic     mul_issued_q;
	operand_t mul_x;
	operand_t mul_result;
	mm_stat_t mm_stat;

	operand_t modulus_q;
	operand_t base_q;
	operand_t exp_q;
	operand_t res_q;
	logic     out_valid_q;
	operand_t power_q;

	assign word = ucode_rom(pc_q);

	// Next step
	always_comb begin
		case (word.op)
			OP_WAIT_IN: step_done = in_valid;
			OP_MUL:     step_done = mm_stat.done;
			OP_EMIT:    step_done = !out_valid_q || out_ready;
			default:    step_done = 1'b1;
		endcase
		case (word.cond)
			COND_ALWAYS:      cond_true = 1'b1;
			COND_M_ZERO:      cond_true = (modulus_q == '0);
			COND_EXP_ZERO:    cond_true = (exp_q == '0);
			COND_EXP_BIT_CLR: cond_true = !exp_q[0];
			default:          cond_true = 1'b0;
		endcase
		pc_d = pc_q;
		if (step_done) begin
			pc_d = cond_true ? word.target : step_t'(pc_q + 4'd1);
		end
	end

	// Step outputs
	always_comb begin
		in_ready  = (word.op == OP_WAIT_IN);
		mul_start = (word.op == OP_MUL) && !mul_issued_q;
		case (word.x_sel)
			X_RES:   mul_x = res_q;
			X_BASE:  mul_x = base_q;
			default: mul_x = operand_t'(1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= STEP_IDLE;
			mul_issued_q <= 1'b0;
			modulus_q    <= MODULUS_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (mul_start) begin
				mul_issued_q <= 1'b1;
			end else if (mm_stat.done) begin
				mul_issued_q <= 1'b0;
			end
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
			end
			if (word.op == OP_EMIT && step_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_done) begin
			case (word.op)
				OP_WAIT_IN: begin
					base_q <= base_value;
					exp_q  <= exponent;
					res_q  <= operand_t'(1);
				end
				OP_MUL: begin
					if (word.dest == DEST_BASE) begin
						base_q <= mul_result;
					end
					if (word.dest == DEST_RES) begin
						res_q <= mul_result;
					end
				end
				OP_EMIT: begin
					power_q <= res_q;
				end
				default: begin
					if (word.clr_res) begin
						res_q <= '0;
					end
				end
			endcase
			if (word.shift_exp) begin
				exp_q <= exp_q >> 1;
			end
		end
	end

	modexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (base_q),
		.m      (modulus_q),
		.result (mul_result),
		.stat   (mm_stat)
	);

	assign out_valid    = out_valid_q;
	assign power_result = power_q;

	`MX_ASSERT_SAME(a_start_when_free, mul_start, !mm_stat.busy && !mm_stat.done, "start while busy")
	`MX_ASSERT_SAME(a_done_was_issued, mm_stat.done, mul_issued_q && word.op == OP_MUL, "stray done")
	`MX_ASSERT_NEXT(a_emit_sets_valid, word.op == OP_EMIT && step_done, out_valid && pc_q == STEP_IDLE, "no result")

endmodule

`default_nettype wire
